### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; they expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication violated");

`endif

### hw/rtl/gtg_ss_pkg.sv
// Constants and types for the go-to-goal skid-steer controller.
package gtg_ss_pkg;

	typedef logic signed [51:0] cord_t;
	typedef logic signed [27:0] angle_acc_t;

	localparam int ATAN_ENTRIES = 24;

	localparam logic [23:0] ATAN_Q24 [ATAN_ENTRIES] = '{
		24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
		24'd1047214, 24'd524117, 24'd262123, 24'd131069,
		24'd65536, 24'd32768, 24'd16384, 24'd8192,
		24'd4096, 24'd2048, 24'd1024, 24'd512,
		24'd256, 24'd128, 24'd64, 24'd32,
		24'd16, 24'd8, 24'd4, 24'd2
	};

	localparam angle_acc_t HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [16:0] ANGLE_LIMIT = 17'sd25736;

	localparam logic [1:0] MODE_REST  = 2'd0;
	localparam logic [1:0] MODE_TURN  = 2'd1;
	localparam logic [1:0] MODE_DRIVE = 2'd2;

	localparam logic [2:0] REG_ORIGIN_LAT  = 3'd0;
	localparam logic [2:0] REG_ORIGIN_LON  = 3'd1;
	localparam logic [2:0] REG_SCALE       = 3'd2;
	localparam logic [2:0] REG_STOP_DIST   = 3'd3;
	localparam logic [2:0] REG_HEAD_THRESH = 3'd4;
	localparam logic [2:0] REG_TURN_SPEED  = 3'd5;
	localparam logic [2:0] REG_DRIVE_SPEED = 3'd6;
	localparam logic [2:0] REG_HALF_TRACK  = 3'd7;

	localparam logic [31:0] SCALE_RST       = 32'd455966720;
	localparam logic [31:0] STOP_DIST_RST   = 32'd32768;
	localparam logic [15:0] HEAD_THRESH_RST = 16'd715;
	localparam logic [14:0] TURN_SPEED_RST  = 15'd256;
	localparam logic [14:0] DRIVE_SPEED_RST = 15'd256;
	localparam logic [15:0] HALF_TRACK_RST  = 16'd51;

endpackage

### hw/rtl/go_to_goal_skid_steer_unit.sv
// Go-to-goal heading controller for a skid-steer robot, fully pipelined.
//
// Usage: each input word carries the robot pose (x, y in Q16.16, yaw in Q3.13) and a
// target latitude and longitude in Q10.32 degrees. Each accepted word yields exactly one
// output word with the right and left wheel speeds (Q8.8, saturated) and the motion mode.
// Both channels use valid/ready; a word moves when valid and ready are high at a clock edge.
// Configuration registers are written through cfg_we/cfg_index/cfg_data with no wait state;
// they should only be changed while no word is in flight.
// The pipeline has eight front-end stages, one stage per CORDIC micro-rotation, a rounding
// stage, a decision stage and the output register. Throughput is one word per cycle while
// the receiver is ready. Every stage has its own valid bit and advances when its successor
// is empty or moving, so a stalled receiver lets bubbles collapse and the block keeps
// accepting words until every stage is full; nothing is dropped or repeated.
// Reset (arst_n low) empties the pipeline and loads the documented register defaults.
`include "assert_macros.svh"

module go_to_goal_skid_steer_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [41:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] robot_x,
	input  logic signed [31:0] robot_y,
	input  logic signed [15:0] robot_yaw,
	input  logic signed [41:0] target_latitude,
	input  logic signed [41:0] target_longitude,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] right_wheel_speed,
	output logic signed [15:0] left_wheel_speed,
	output logic [1:0]         motion_mode
);
	import gtg_ss_pkg::*;

	// Stage positions in the valid/enable vectors.
	localparam int ST_C0 = 8;
	localparam int ST_R  = ST_C0 + CORDIC_STEPS;
	localparam int ST_D  = ST_R + 1;
	localparam int ST_O  = ST_R + 2;
	localparam int NS    = ST_O + 1;

	// Configuration registers.
	logic signed [41:0] origin_lat_q, origin_lon_q;
	logic [31:0]        scale_q, stop_dist_q;
	logic [15:0]        head_thresh_q, half_track_q;
	logic [14:0]        turn_speed_q, drive_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_lat_q  <= '0;
			origin_lon_q  <= '0;
			scale_q       <= SCALE_RST;
			stop_dist_q   <= STOP_DIST_RST;
			head_thresh_q <= HEAD_THRESH_RST;
			turn_speed_q  <= TURN_SPEED_RST;
			drive_speed_q <= DRIVE_SPEED_RST;
			half_track_q  <= HALF_TRACK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_LAT:  origin_lat_q  <= cfg_data;
				REG_ORIGIN_LON:  origin_lon_q  <= cfg_data;
				REG_SCALE:       scale_q       <= cfg_data[31:0];
				REG_STOP_DIST:   stop_dist_q   <= cfg_data[31:0];
				REG_HEAD_THRESH: head_thresh_q <= cfg_data[15:0];
				REG_TURN_SPEED:  turn_speed_q  <= cfg_data[14:0];
				REG_DRIVE_SPEED: drive_speed_q <= cfg_data[14:0];
				REG_HALF_TRACK:  half_track_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The turn wheel term depends only on configuration, so it is computed outside the pipeline and registered.
	logic [30:0] turn_prod;
	logic [31:0] turn_rnd;
	logic [14:0] turn_term_q;

	assign turn_prod = turn_speed_q * half_track_q;
	assign turn_rnd  = {1'b0, turn_prod} + 32'd128;

	always_ff @(posedge clk) begin
		turn_term_q <= (turn_rnd[31:8] > 24'd32767) ? 15'h7fff : turn_rnd[22:8];
	end

	// Pipeline flow control: a stage may load when it is empty or its content moves on.
	logic [NS-1:0] vld_q, en;

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[ST_O];

	// Stage 1: coordinate differences from the origin.
	logic signed [42:0] latd_s1, lond_s1;
	logic signed [31:0] rx_s1, ry_s1;
	logic signed [15:0] yaw_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			latd_s1 <= {target_latitude[41], target_latitude} - {origin_lat_q[41], origin_lat_q};
			lond_s1 <= {target_longitude[41], target_longitude}
				- {origin_lon_q[41], origin_lon_q};
			rx_s1   <= robot_x;
			ry_s1   <= robot_y;
			yaw_s1  <= robot_yaw;
		end
	end

	// Stage 2: magnitudes and signs.
	logic [43:0]        latx, lonx;
	logic [43:0]        alat_s2, alon_s2;
	logic               nlat_s2, nlon_s2;
	logic signed [31:0] rx_s2, ry_s2;
	logic signed [15:0] yaw_s2;

	assign latx = {latd_s1[42], latd_s1};
	assign lonx = {lond_s1[42], lond_s1};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			alat_s2 <= latd_s1[42] ? (~latx + 44'd1) : latx;
			alon_s2 <= lond_s1[42] ? (~lonx + 44'd1) : lonx;
			nlat_s2 <= latd_s1[42];
			nlon_s2 <= lond_s1[42];
			rx_s2   <= rx_s1;
			ry_s2   <= ry_s1;
			yaw_s2  <= yaw_s1;
		end
	end

	// Stage 3: partial products of the scale, split into 16-bit halves.
	logic [59:0]        plh_s3, pll_s3, ploh_s3, plol_s3;
	logic               nlat_s3, nlon_s3;
	logic signed [31:0] rx_s3, ry_s3;
	logic signed [15:0] yaw_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			plh_s3  <= alat_s2 * scale_q[31:16];
			pll_s3  <= alat_s2 * scale_q[15:0];
			ploh_s3 <= alon_s2 * scale_q[31:16];
			plol_s3 <= alon_s2 * scale_q[15:0];
			nlat_s3 <= nlat_s2;
			nlon_s3 <= nlon_s2;
			rx_s3   <= rx_s2;
			ry_s3   <= ry_s2;
			yaw_s3  <= yaw_s2;
		end
	end

	// Stage 4: combine halves, drop 28 fraction bits, apply signs (y axis is negated).
	logic [75:0]        sum_lat, sum_lon;
	logic [48:0]        qlat, qlon;
	logic signed [48:0] tx_s4, ty_s4;
	logic signed [31:0] rx_s4, ry_s4;
	logic signed [15:0] yaw_s4;

	assign sum_lat = {plh_s3, 16'b0} + {16'b0, pll_s3};
	assign sum_lon = {ploh_s3, 16'b0} + {16'b0, plol_s3};
	assign qlat    = {1'b0, sum_lat[75:28]};
	assign qlon    = {1'b0, sum_lon[75:28]};

	always_ff @(posedge clk) begin
		if (en[3]) begin
			tx_s4  <= nlat_s3 ? -$signed(qlat) : $signed(qlat);
			ty_s4  <= nlon_s3 ? $signed(qlon) : -$signed(qlon);
			rx_s4  <= rx_s3;
			ry_s4  <= ry_s3;
			yaw_s4 <= yaw_s3;
		end
	end

	// Stage 5: offset from robot to goal.
	logic signed [49:0] dx_s5, dy_s5;
	logic signed [15:0] yaw_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			dx_s5  <= {tx_s4[48], tx_s4} - 50'(rx_s4);
			dy_s5  <= {ty_s4[48], ty_s4} - 50'(ry_s4);
			yaw_s5 <= yaw_s4;
		end
	end

	// Stage 6: magnitudes for the distance test, quadrant pre-rotation for the CORDIC.
	logic [49:0]        adx, ady;
	cord_t              dxw, dyw;
	logic [31:0]        ax_s6, ay_s6;
	logic               big_s6, zero_s6;
	cord_t              x_s6, y_s6;
	angle_acc_t         z_s6;
	logic signed [15:0] yaw_s6;

	assign adx = dx_s5[49] ? 50'(-dx_s5) : dx_s5;
	assign ady = dy_s5[49] ? 50'(-dy_s5) : dy_s5;
	assign dxw = 52'(dx_s5);
	assign dyw = 52'(dy_s5);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ax_s6   <= adx[31:0];
			ay_s6   <= ady[31:0];
			big_s6  <= (|adx[49:32]) || (|ady[49:32]);
			zero_s6 <= (dx_s5 == '0) && (dy_s5 == '0);
			yaw_s6  <= yaw_s5;
			if (!dx_s5[49]) begin
				x_s6 <= dxw;
				y_s6 <= dyw;
				z_s6 <= '0;
			end else if (!dy_s5[49]) begin
				x_s6 <= dyw;
				y_s6 <= -dxw;
				z_s6 <= HALF_PI_Q24;
			end else begin
				x_s6 <= -dyw;
				y_s6 <= dxw;
				z_s6 <= -HALF_PI_Q24;
			end
		end
	end

	// Stage 7: squares.
	logic [63:0]        sx_s7, sy_s7, sd2_s7;
	logic               big_s7, zero_s7;
	cord_t              x_s7, y_s7;
	angle_acc_t         z_s7;
	logic signed [15:0] yaw_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			sx_s7   <= ax_s6 * ax_s6;
			sy_s7   <= ay_s6 * ay_s6;
			sd2_s7  <= stop_dist_q * stop_dist_q;
			big_s7  <= big_s6;
			zero_s7 <= zero_s6;
			x_s7    <= x_s6;
			y_s7    <= y_s6;
			z_s7    <= z_s6;
			yaw_s7  <= yaw_s6;
		end
	end

	// Stage 8: distance test. A 65-bit sum covers the overflow case.
	logic [64:0]        dist2;
	logic               near_s8, zero_s8;
	cord_t              x_s8, y_s8;
	angle_acc_t         z_s8;
	logic signed [15:0] yaw_s8;

	assign dist2 = {1'b0, sx_s7} + {1'b0, sy_s7};

	always_ff @(posedge clk) begin
		if (en[7]) begin
			near_s8 <= !big_s7 && (dist2 < {1'b0, sd2_s7});
			zero_s8 <= zero_s7;
			x_s8    <= x_s7;
			y_s8    <= y_s7;
			z_s8    <= z_s7;
			yaw_s8  <= yaw_s7;
		end
	end

	// CORDIC vectoring, one micro-rotation per stage.
	cord_t              cx_sc   [CORDIC_STEPS];
	cord_t              cy_sc   [CORDIC_STEPS];
	angle_acc_t         cz_sc   [CORDIC_STEPS];
	logic signed [15:0] cyaw_sc [CORDIC_STEPS];
	logic               cnear_sc[CORDIC_STEPS];
	logic               czero_sc[CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cord
		cord_t              xi, yi;
		angle_acc_t         zi, ai;
		logic signed [15:0] yawi;
		logic               neari, zeroi;

		if (i == 0) begin : g_first
			assign xi    = x_s8;
			assign yi    = y_s8;
			assign zi    = z_s8;
			assign yawi  = yaw_s8;
			assign neari = near_s8;
			assign zeroi = zero_s8;
		end else begin : g_next
			assign xi    = cx_sc[i-1];
			assign yi    = cy_sc[i-1];
			assign zi    = cz_sc[i-1];
			assign yawi  = cyaw_sc[i-1];
			assign neari = cnear_sc[i-1];
			assign zeroi = czero_sc[i-1];
		end

		assign ai = $signed({4'b0, ATAN_Q24[i]});

		always_ff @(posedge clk) begin
			if (en[ST_C0+i]) begin
				if (!yi[51]) begin
					cx_sc[i] <= xi + (yi >>> i);
					cy_sc[i] <= yi - (xi >>> i);
					cz_sc[i] <= zi + ai;
				end else begin
					cx_sc[i] <= xi - (yi >>> i);
					cy_sc[i] <= yi + (xi >>> i);
					cz_sc[i] <= zi - ai;
				end
				cyaw_sc[i]  <= yawi;
				cnear_sc[i] <= neari;
				czero_sc[i] <= zeroi;
			end
		end
	end

	// Rounding stage: Q4.24 to Q3.13 with round half up, then clamp to plus or minus pi; a zero offset gives zero.
	angle_acc_t         zp;
	logic signed [16:0] zr;
	logic signed [15:0] ang_sr, yaw_sr;
	logic               near_sr;

	assign zp = cz_sc[CORDIC_STEPS-1] + 28'sd1024;
	assign zr = zp[27:11];

	always_ff @(posedge clk) begin
		if (en[ST_R]) begin
			if (czero_sc[CORDIC_STEPS-1]) begin
				ang_sr <= '0;
			end else if (zr > ANGLE_LIMIT) begin
				ang_sr <= ANGLE_LIMIT[15:0];
			end else if (zr < -ANGLE_LIMIT) begin
				ang_sr <= 16'(-ANGLE_LIMIT);
			end else begin
				ang_sr <= zr[15:0];
			end
			yaw_sr  <= cyaw_sc[CORDIC_STEPS-1];
			near_sr <= cnear_sc[CORDIC_STEPS-1];
		end
	end

	// Decision stage: rest, turn in place, or drive. The heading error is not wrapped.
	logic signed [16:0] hdiff;
	logic [16:0]        ahdiff;
	logic [1:0]         mode_sd;
	logic signed [15:0] v_sd, w_sd;

	assign hdiff  = {ang_sr[15], ang_sr} - {yaw_sr[15], yaw_sr};
	assign ahdiff = hdiff[16] ? 17'(-hdiff) : hdiff;

	always_ff @(posedge clk) begin
		if (en[ST_D]) begin
			if (near_sr) begin
				mode_sd <= MODE_REST;
				v_sd    <= '0;
				w_sd    <= '0;
			end else if (ahdiff > {1'b0, head_thresh_q}) begin
				mode_sd <= MODE_TURN;
				v_sd    <= '0;
				w_sd    <= (ang_sr > yaw_sr) ? $signed({1'b0, turn_term_q})
					: -$signed({1'b0, turn_term_q});
			end else begin
				mode_sd <= MODE_DRIVE;
				v_sd    <= $signed({1'b0, drive_speed_q});
				w_sd    <= '0;
			end
		end
	end

	// Output register: wheel sums with saturation.
	logic signed [16:0] rsum, lsum;

	assign rsum = {v_sd[15], v_sd} + {w_sd[15], w_sd};
	assign lsum = {v_sd[15], v_sd} - {w_sd[15], w_sd};

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767) begin
			return 16'sh7fff;
		end else if (v < -17'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en[ST_O]) begin
			right_wheel_speed <= sat16(rsum);
			left_wheel_speed  <= sat16(lsum);
			motion_mode       <= mode_sd;
		end
	end

	`ASSERT_IMPLIES(a_rest_stopped, out_valid && (motion_mode == MODE_REST),
		(right_wheel_speed == '0) && (left_wheel_speed == '0))
	`ASSERT_IMPLIES(a_drive_straight, out_valid && (motion_mode == MODE_DRIVE),
		(right_wheel_speed == left_wheel_speed) && !right_wheel_speed[15])
	`ASSERT_IMPLIES(a_turn_opposed, out_valid && (motion_mode == MODE_TURN),
		right_wheel_speed == -left_wheel_speed)
	`ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_q[0])

endmodule

### tb/go_to_goal_skid_steer_unit_tb.sv
// Self-checking testbench for the go-to-goal skid-steer controller.
module go_to_goal_skid_steer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gtg_ss_pkg::*;

	localparam int STEPS = 16;
	localparam int LATENCY = STEPS + 11;
	localparam int CYCLE_LIMIT = 900000;
	localparam int RANDOM_WORDS = 1750;
	localparam logic signed [15:0] YAW_MAX = 16'sd25736;

	// One input word and one wheel command.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] yaw;
		logic signed [41:0] lat;
		logic signed [41:0] lon;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] right;
		logic signed [15:0] left;
		logic [1:0] mode;
	} wheel_cmd_t;

	// A directed row: the pose, and a typed-in command when it is obvious.
	typedef struct {
		pose_t pose;
		bit known;
		wheel_cmd_t cmd;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [41:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] robot_x;
	logic signed [31:0] robot_y;
	logic signed [15:0] robot_yaw;
	logic signed [41:0] target_latitude;
	logic signed [41:0] target_longitude;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] right_wheel_speed;
	logic signed [15:0] left_wheel_speed;
	logic [1:0] motion_mode;

	go_to_goal_skid_steer_unit #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.robot_x(robot_x), .robot_y(robot_y), .robot_yaw(robot_yaw),
		.target_latitude(target_latitude), .target_longitude(target_longitude),
		.out_valid(out_valid), .out_ready(out_ready),
		.right_wheel_speed(right_wheel_speed), .left_wheel_speed(left_wheel_speed),
		.motion_mode(motion_mode)
	);

	// The predictor's own copy of the configuration registers.
	logic signed [41:0] org_lat, org_lon;
	logic [31:0] scale, stop_dist;
	logic [15:0] head_thresh, half_track;
	logic [14:0] turn_speed, drive_speed;

	wheel_cmd_t pending_cmds[$];
	int mismatches;
	int cycles = 0;
	int send_idle_pct, recv_stall_pct;
	bit timed_out;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The cycle counter guards the whole run against a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Some tests failed");
			$finish;
		end
	end

	// Degrees to local Q16.16: the magnitude of the exact product is shifted by 28
	// bits (truncating toward zero) and the sign is applied afterward.
	function automatic logic signed [75:0] deg_to_local(input logic signed [43:0] d,
			input logic [31:0] s);
		logic [43:0] a;
		logic [75:0] p;
		a = d < 0 ? -d : d;
		p = ({32'd0, a} * {44'd0, s}) >> 28;
		return d < 0 ? -$signed(p) : $signed(p);
	endfunction

	// Arithmetic shift right of a wide signed value (floor).
	function automatic logic signed [79:0] floor_shift(input logic signed [79:0] v,
			input int sh);
		return v >>> sh;
	endfunction

	// CORDIC vectoring bearing in Q3.13, saturated to plus or minus pi.
	function automatic logic signed [31:0] cordic_bearing(input logic signed [79:0] x0,
			input logic signed [79:0] y0);
		logic signed [79:0] x, y, t, xs, ys;
		logic signed [63:0] z;
		x = x0;
		y = y0;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HALF_PI_Q24;
			end else begin
				x = -y;
				y = t;
				z = -HALF_PI_Q24;
			end
		end
		for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + $signed({40'd0, ATAN_Q24[i]});
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - $signed({40'd0, ATAN_Q24[i]});
			end
		end
		z = (z + 1024) >>> 11;
		if (z > 25736)
			z = 25736;
		if (z < -25736)
			z = -25736;
		return z[31:0];
	endfunction

	function automatic logic signed [15:0] clamp16(input logic signed [31:0] v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// Works out the wheel command that one pose should produce.
	function automatic wheel_cmd_t steer_command(input pose_t p);
		logic signed [79:0] tx, ty, dx, dy;
		logic [79:0] ax, ay;
		logic [127:0] dist_sq, stop_sq;
		logic signed [31:0] ang, diff, v, w;
		logic [31:0] s;
		bit at_rest;
		wheel_cmd_t c;
		tx = deg_to_local(44'(p.lat) - 44'(org_lat), scale);
		ty = -deg_to_local(44'(p.lon) - 44'(org_lon), scale);
		dx = tx - 80'(p.x);
		dy = ty - 80'(p.y);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		dist_sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
		stop_sq = 128'(stop_dist) * 128'(stop_dist);
		// The block keeps dx^2 and dy^2 in 64 bits each; anything wider never rests.
		at_rest = ax < 80'h1_0000_0000 && ay < 80'h1_0000_0000
			&& dist_sq < 128'h1_0000_0000_0000_0000 && dist_sq < stop_sq;
		v = 0;
		w = 0;
		c.mode = MODE_REST;
		if (!at_rest) begin
			ang = cordic_bearing(dx, dy);
			diff = ang - 32'(p.yaw);
			if ((diff < 0 ? -diff : diff) > $signed({16'd0, head_thresh})) begin
				s = (32'(turn_speed) * 32'(half_track) + 128) >> 8;
				if (s > 32767)
					s = 32767;
				w = ang > 32'(p.yaw) ? $signed(s) : -$signed(s);
				c.mode = MODE_TURN;
			end else begin
				v = 32'(drive_speed);
				c.mode = MODE_DRIVE;
			end
		end
		c.right = clamp16(v + w);
		c.left = clamp16(v - w);
		return c;
	endfunction

	// Writes a register in the block and in the predictor. Only called while idle.
	task automatic write_reg(input logic [2:0] idx, input logic [41:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ORIGIN_LAT:  org_lat = val;
			REG_ORIGIN_LON:  org_lon = val;
			REG_SCALE:       scale = val[31:0];
			REG_STOP_DIST:   stop_dist = val[31:0];
			REG_HEAD_THRESH: head_thresh = val[15:0];
			REG_TURN_SPEED:  turn_speed = val[14:0];
			REG_DRIVE_SPEED: drive_speed = val[14:0];
			REG_HALF_TRACK:  half_track = val[15:0];
			default: ;
		endcase
	endtask

	// Offers one word, holding it until accepted, with random idle cycles first.
	// Valid stays high after acceptance so that the next word can follow directly.
	task automatic send_pose(input pose_t p, input bit known, input wheel_cmd_t cmd);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{robot_x, robot_y, robot_yaw, target_latitude, target_longitude} <= p;
		do
			@(posedge clk);
		while (!in_ready);
		pending_cmds.push_back(known ? cmd : steer_command(p));
	endtask

	// Waits for every expected word, then for the pipeline to drain.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// The receiver stalls at random and checks each accepted word in order.
	always @(posedge clk) begin
		wheel_cmd_t want, got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{right_wheel_speed, left_wheel_speed, motion_mode};
				if (pending_cmds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected word: right %0d left %0d mode %0d",
							got.right, got.left, got.mode);
				end else begin
					want = pending_cmds.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: want r %0d l %0d m %0d, got r %0d l %0d m %0d",
								want.right, want.left, want.mode,
								got.right, got.left, got.mode);
					end
				end
			end
			out_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// A random pose: mostly targets near the robot so that the distance and bearing
	// logic is exercised, some fully random words as noise.
	function automatic pose_t random_pose();
		pose_t p;
		logic signed [63:0] near;
		p.x = $urandom;
		p.y = $urandom;
		p.yaw = $urandom_range(99) < 90 ? 16'($signed($urandom_range(51472)) - 25736)
			: 16'($urandom);
		p.lat = 42'({$urandom, $urandom});
		p.lon = 42'({$urandom, $urandom});
		if ($urandom_range(99) < 75) begin
			// Small signed offsets from the origin give targets within a few metres.
			near = $signed(64'($urandom_range(8000))) - 4000;
			p.lat = 42'(org_lat) + 42'(near * ($urandom_range(1) ? 1 : 97));
			near = $signed(64'($urandom_range(8000))) - 4000;
			p.lon = 42'(org_lon) + 42'(near * ($urandom_range(1) ? 1 : 97));
			p.x = $signed(32'($urandom_range(1 << 20))) - (1 << 19);
			p.y = $signed(32'($urandom_range(1 << 20))) - (1 << 19);
		end
		return p;
	endfunction

	row_t rows[$];
	wheel_cmd_t rest_cmd;
	wheel_cmd_t none_cmd;

	initial begin
		pose_t p;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		{robot_x, robot_y, robot_yaw, target_latitude, target_longitude} = '0;
		org_lat = '0;
		org_lon = '0;
		scale = SCALE_RST;
		stop_dist = STOP_DIST_RST;
		head_thresh = HEAD_THRESH_RST;
		turn_speed = TURN_SPEED_RST;
		drive_speed = DRIVE_SPEED_RST;
		half_track = HALF_TRACK_RST;
		rest_cmd = '{16'sd0, 16'sd0, MODE_REST};
		none_cmd = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset configuration. The robot sitting on the
		// origin target rests; the rest follow the predictor.
		rows.push_back('{'{32'sd0, 32'sd0, 16'sd0, 42'sd0, 42'sd0}, 1, rest_cmd});
		rows.push_back('{'{32'sd0, 32'sd0, YAW_MAX, 42'sd0, 42'sd0}, 1, rest_cmd});
		rows.push_back('{'{32'sh7fffffff, 32'sh80000000, -YAW_MAX,
			42'sh1ff_ffff_ffff, 42'sh200_0000_0000}, 0, none_cmd});
		rows.push_back('{'{32'sh80000000, 32'sh7fffffff, YAW_MAX,
			42'sh200_0000_0000, 42'sh1ff_ffff_ffff}, 0, none_cmd});
		rows.push_back('{'{32'sd655360, 32'sd0, 16'sd0, 42'sd0, 42'sd0}, 0, none_cmd});
		rows.push_back('{'{-32'sd655360, 32'sd0, 16'sd0, 42'sd0, 42'sd0}, 0, none_cmd});
		rows.push_back('{'{32'sd0, 32'sd655360, 16'sd0, 42'sd0, 42'sd0}, 0, none_cmd});
		rows.push_back('{'{32'sd0, -32'sd655360, 16'sd0, 42'sd0, 42'sd0}, 0, none_cmd});
		rows.push_back('{'{-32'sd655360, -32'sd1, 16'sh7fff, 42'sd0, 42'sd0}, 0, none_cmd});
		rows.push_back('{'{-32'sd655360, 32'sd1, 16'sh8000, 42'sd0, 42'sd0}, 0, none_cmd});
		rows.push_back('{'{32'sd100, 32'sd100, 16'sd0, 42'sd4000, -42'sd4000}, 0, none_cmd});
		foreach (rows[i])
			send_pose(rows[i].pose, rows[i].known, rows[i].cmd);
		drain();

		// Zero offset with a zero stop distance: the bearing is zero, so yaw decides.
		write_reg(REG_STOP_DIST, 42'd0);
		send_pose('{32'sd0, 32'sd0, 16'sd0, 42'sd0, 42'sd0}, 0, none_cmd);
		send_pose('{32'sd0, 32'sd0, YAW_MAX, 42'sd0, 42'sd0}, 0, none_cmd);
		drain();
		// Extreme speeds and track saturate the turn term.
		write_reg(REG_TURN_SPEED, 42'd32767);
		write_reg(REG_HALF_TRACK, 42'd65535);
		write_reg(REG_DRIVE_SPEED, 42'd32767);
		write_reg(REG_HEAD_THRESH, 42'd0);
		send_pose('{32'sd0, 32'sd0, YAW_MAX, 42'sd0, 42'sd0}, 0, none_cmd);
		send_pose('{32'sd0, 32'sd0, -YAW_MAX, 42'sd0, 42'sd0}, 0, none_cmd);
		send_pose('{32'sd0, 32'sd0, 16'sd0, 42'sd0, 42'sd0}, 0, none_cmd);
		drain();
		// The half track goes back to its reset value.
		write_reg(REG_HALF_TRACK, 42'd51);

		// Random phases: all but the first load a new configuration; the idling pattern cycles through four settings.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			case (phase)
				0: ;
				7: begin
					write_reg(REG_ORIGIN_LAT, 42'h1ff_ffff_ffff);
					write_reg(REG_ORIGIN_LON, 42'h200_0000_0000);
					write_reg(REG_SCALE, 42'hffff_ffff);
					write_reg(REG_STOP_DIST, 42'hffff_ffff);
					write_reg(REG_HEAD_THRESH, 42'd51472);
				end
				default: begin
					write_reg(REG_ORIGIN_LAT, 42'({$urandom, $urandom}));
					write_reg(REG_ORIGIN_LON, 42'({$urandom, $urandom}));
					write_reg(REG_SCALE, 42'($urandom_range(1) ? $urandom : SCALE_RST));
					write_reg(REG_STOP_DIST, 42'($urandom_range(1 << 18)));
					write_reg(REG_HEAD_THRESH, 42'($urandom_range(1) ? $urandom_range(51472)
						: $urandom_range(2000)));
					write_reg(REG_TURN_SPEED, 42'($urandom_range(32767)));
					write_reg(REG_DRIVE_SPEED, 42'($urandom_range(32767)));
					write_reg(REG_HALF_TRACK, 42'($urandom_range(1) ? $urandom_range(65535)
						: $urandom_range(300)));
				end
			endcase
			for (int k = 0; k < RANDOM_WORDS / 8; k++) begin
				p = random_pose();
				send_pose(p, 0, none_cmd);
				// Once per phase the sender waits for every result before going on.
				if (k == 100) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_cmds.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
